[rtl/core/ttc_pkg.sv]
// ----------------------------------------------------------------------------
// ttc_pkg: shared types and constants for the tick timeout / calendar clock
// Payload structs, command codes, calendar limits and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ttc_pkg;

    localparam int NUM_TIMEOUTS_DEF = 8;
    localparam int CNT_W            = 16;
    localparam int MASK_W           = 8;
    localparam int IDX_W            = 4;

    localparam logic [7:0] SEC_LIMIT    = 8'd59;
    localparam logic [7:0] MIN_LIMIT    = 8'd59;
    localparam logic [7:0] HOUR_LIMIT   = 8'd23;
    localparam logic [7:0] DAY_LIMIT    = 8'd30;
    localparam logic [7:0] MONTH_LIMIT  = 8'd12;
    localparam logic [7:0] RELOAD_RESET = 8'd100;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_LOAD     = 3'd1,
        CMD_SET_TIME = 3'd2,
        CMD_SET_DATE = 3'd3,
        CMD_READ     = 3'd4
    } ttc_cmd_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [IDX_W-1:0] timer_index;
        logic [CNT_W-1:0] load_value;
        logic [7:0]       value_a;
        logic [7:0]       value_b;
        logic [7:0]       value_c;
    } ttc_req_t;

    typedef struct packed {
        logic [7:0]        second;
        logic [7:0]        minute;
        logic [7:0]        hour_now;
        logic [7:0]        day_now;
        logic [7:0]        month_now;
        logic [7:0]        year_now;
        logic [MASK_W-1:0] expired_mask;
        logic [CNT_W-1:0]  read_count;
        logic              read_expired;
    } ttc_rsp_t;

    typedef logic [7:0] ttc_cfg_t;

    // calendar state as seen by the output stage
    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
    } ttc_time_t;

    // sequencer -> counter bank
    typedef struct packed {
        logic             en;
        logic             dec;
        logic             load_hit;
        logic [CNT_W-1:0] load_value;
    } ttc_bank_ctl_t;

    // sequencer -> calendar
    typedef struct packed {
        logic       tick;
        logic       set_time;
        logic       set_date;
        logic [7:0] value_a;
        logic [7:0] value_b;
        logic [7:0] value_c;
    } ttc_cal_ctl_t;

endpackage

`default_nettype wire

[rtl/core/ttc_stream_if.sv]
// ----------------------------------------------------------------------------
// ttc_stream_if: valid/ready channel
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/ttc_timer_bank.sv]
// ----------------------------------------------------------------------------
// ttc_timer_bank: timeout counter storage with shared update unit
// One counter is visited per cycle while ctl.en is high: load, decrement-if-nonzero or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_timer_bank #(
    parameter  int NUM_TIMEOUTS = ttc_pkg::NUM_TIMEOUTS_DEF,
    localparam int IW           = (NUM_TIMEOUTS > 1) ? $clog2(NUM_TIMEOUTS) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [IW-1:0]              idx,
    input  wire ttc_pkg::ttc_bank_ctl_t     ctl,
    output logic [ttc_pkg::CNT_W-1:0]       cur_count,
    output logic                            new_zero
);
    import ttc_pkg::*;

    logic [CNT_W-1:0] count_reg [NUM_TIMEOUTS];
    logic [CNT_W-1:0] new_count;

    assign cur_count = count_reg[idx];

    // shared update unit
    always_comb
    begin
        if (ctl.load_hit)
        begin
            new_count = ctl.load_value;
        end
        else if (ctl.dec && (cur_count != '0))
        begin
            new_count = cur_count - CNT_W'(1);
        end
        else
        begin
            new_count = cur_count;
        end
        new_zero = (new_count == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMEOUTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (ctl.en)
        begin
            count_reg[idx] <= new_count;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ttc_calendar.sv]
// ----------------------------------------------------------------------------
// ttc_calendar: tick prescaler and second..year calendar
// Holds the reload register; applies tick, set-time and set-date strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_calendar (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [7:0]            cfg_data,
    input  wire ttc_pkg::ttc_cal_ctl_t ctl,
    output ttc_pkg::ttc_time_t         now
);
    import ttc_pkg::*;

    logic [7:0] reload_reg;
    logic [7:0] presc_reg;
    logic [7:0] presc_next;
    ttc_time_t  time_reg;
    ttc_time_t  time_next;
    ttc_time_t  adv;

    // 8-bit increment; past the limit it restarts at 0 and carries
    function automatic logic [8:0] bump(input logic [7:0] v, input logic [7:0] lim);
        logic [7:0] n;
        n = v + 8'd1;
        if (n > lim)
        begin
            bump = {1'b1, 8'd0};
        end
        else
        begin
            bump = {1'b0, n};
        end
    endfunction

    // one-second advance with carry ripple
    always_comb
    begin
        logic [8:0] r;
        adv = time_reg;
        r = bump(time_reg.sec, SEC_LIMIT);
        adv.sec = r[7:0];
        if (r[8])
        begin
            r = bump(time_reg.min, MIN_LIMIT);
            adv.min = r[7:0];
            if (r[8])
            begin
                r = bump(time_reg.hour, HOUR_LIMIT);
                adv.hour = r[7:0];
                if (r[8])
                begin
                    r = bump(time_reg.day, DAY_LIMIT);
                    adv.day = r[7:0];
                    if (r[8])
                    begin
                        r = bump(time_reg.month, MONTH_LIMIT);
                        adv.month = r[7:0];
                        if (r[8])
                        begin
                            adv.year = time_reg.year + 8'd1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        time_next  = time_reg;
        presc_next = presc_reg;
        if (ctl.tick)
        begin
            if (presc_reg != 8'd0)
            begin
                presc_next = presc_reg - 8'd1;
            end
            else
            begin
                presc_next = reload_reg;
                time_next  = adv;
            end
        end
        else if (ctl.set_time)
        begin
            time_next.hour = ctl.value_a;
            time_next.min  = ctl.value_b;
            time_next.sec  = ctl.value_c;
        end
        else if (ctl.set_date)
        begin
            time_next.year  = ctl.value_a;
            time_next.month = ctl.value_b;
            time_next.day   = ctl.value_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= RELOAD_RESET;
            presc_reg  <= RELOAD_RESET;
            time_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                reload_reg <= cfg_data;
            end
            presc_reg <= presc_next;
            time_reg  <= time_next;
        end
    end

    assign now = time_reg;

endmodule

`default_nettype wire

[rtl/core/tick_timeouts_and_calendar_clock_unit.sv]
// ----------------------------------------------------------------------------
// tick_timeouts_and_calendar_clock_unit: timeout counters and calendar clock
// A sequencer sweeps one shared update unit across the timeout counters, then
// steps the calendar and emits one result beat per request beat.
//
// Usage:
//   req : command beats (tick, load counter, set time, set date, read counter).
//   rsp : one beat per request: clock after the command, expired mask of
//         counters 0..7, and read count / read expired for a read command.
//   cfg : prescaler reload writes, always ready; write only while idle.
//   Timing: a request beat is taken only in the idle state. The sweep visits
//   one counter per cycle through the single shared load/decrement unit, then
//   the calendar is stepped and the result is emitted; the next request can be
//   taken in the same cycle that rsp.valid rises. The sweep length is set by
//   the one counter port.
//   Stall: the result sits in an output register; while it waits the block
//   still takes and processes the next request and holds in its emit state
//   until the register frees up.
//   Reset: counters clear to zero, calendar to zero, prescaler and reload to
//   100; no response pending.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_timeouts_and_calendar_clock_unit #(
    parameter int NUM_TIMEOUTS = ttc_pkg::NUM_TIMEOUTS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ttc_stream_if.sink   req,
    ttc_stream_if.source rsp,
    ttc_stream_if.sink   cfg
);
    import ttc_pkg::*;

    localparam int IW = (NUM_TIMEOUTS > 1) ? $clog2(NUM_TIMEOUTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_CLOCK = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    ttc_req_t          cmd_reg;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]  rd_count_reg, rd_count_next;
    logic              rd_exp_reg, rd_exp_next;
    logic              out_valid_reg, out_valid_next;
    ttc_rsp_t          out_data_reg;

    logic              req_beat;
    logic              emit_go;
    logic [IDX_W-1:0]  idx_ext;
    logic              idx_hit;
    logic              last_idx;

    ttc_bank_ctl_t     bank_ctl;
    ttc_cal_ctl_t      cal_ctl;
    logic [CNT_W-1:0]  cur_count;
    logic              new_zero;
    ttc_time_t         now;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_beat  = req.valid && req.ready;

    assign idx_ext  = IDX_W'(idx_reg);
    assign idx_hit  = (idx_ext == cmd_reg.timer_index);
    assign last_idx = (idx_reg == IW'(NUM_TIMEOUTS - 1));
    // output register frees when empty or its beat is being taken
    assign emit_go  = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    // counter bank control
    always_comb
    begin
        bank_ctl.en         = (state_reg == ST_SWEEP);
        bank_ctl.dec        = (cmd_reg.cmd == CMD_TICK);
        bank_ctl.load_hit   = (cmd_reg.cmd == CMD_LOAD) && idx_hit;
        bank_ctl.load_value = cmd_reg.load_value;
    end

    ttc_timer_bank #(
        .NUM_TIMEOUTS (NUM_TIMEOUTS)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .idx       (idx_reg),
        .ctl       (bank_ctl),
        .cur_count (cur_count),
        .new_zero  (new_zero)
    );

    // calendar gets at most one strobe, in the clock state after the sweep
    always_comb
    begin
        cal_ctl.tick     = (state_reg == ST_CLOCK) && (cmd_reg.cmd == CMD_TICK);
        cal_ctl.set_time = (state_reg == ST_CLOCK) && (cmd_reg.cmd == CMD_SET_TIME);
        cal_ctl.set_date = (state_reg == ST_CLOCK) && (cmd_reg.cmd == CMD_SET_DATE);
        cal_ctl.value_a  = cmd_reg.value_a;
        cal_ctl.value_b  = cmd_reg.value_b;
        cal_ctl.value_c  = cmd_reg.value_c;
    end

    ttc_calendar u_cal (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid && cfg.ready),
        .cfg_data (cfg.data),
        .ctl      (cal_ctl),
        .now      (now)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        rd_count_next  = rd_count_reg;
        rd_exp_next    = rd_exp_reg;
        out_valid_next = out_valid_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    state_next    = ST_SWEEP;
                    idx_next      = '0;
                    mask_next     = '0;
                    rd_count_next = '0;
                    // out-of-range read reports expired; a hit overrides
                    rd_exp_next   = (req.data.cmd == CMD_READ);
                end
            end
            ST_SWEEP:
            begin
                for (int b = 0; b < MASK_W; b++)
                begin
                    if ((b < NUM_TIMEOUTS) && (idx_ext == IDX_W'(b)))
                    begin
                        mask_next[b] = new_zero;
                    end
                end
                if ((cmd_reg.cmd == CMD_READ) && idx_hit)
                begin
                    rd_count_next = cur_count;
                    rd_exp_next   = (cur_count == '0);
                end
                if (last_idx)
                begin
                    state_next = ST_CLOCK;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_CLOCK:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            cmd_reg <= req.data;
        end
        mask_reg     <= mask_next;
        rd_count_reg <= rd_count_next;
        rd_exp_reg   <= rd_exp_next;
        if (emit_go)
        begin
            out_data_reg.second       <= now.sec;
            out_data_reg.minute       <= now.min;
            out_data_reg.hour_now     <= now.hour;
            out_data_reg.day_now      <= now.day;
            out_data_reg.month_now    <= now.month;
            out_data_reg.year_now     <= now.year;
            out_data_reg.expired_mask <= mask_reg;
            out_data_reg.read_count   <= rd_count_reg;
            out_data_reg.read_expired <= rd_exp_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> (state_reg == ST_SWEEP) && (idx_reg == '0))
        else $error("accepted beat did not start sweep at counter 0");

    a_clock_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOCK) |=> (state_reg == ST_EMIT))
        else $error("calendar step not followed by emit");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> rsp.valid && (state_reg == ST_IDLE))
        else $error("emit did not present a result beat");

    a_read_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.data.read_expired && (rsp.data.read_count != '0)))
        else $error("read flagged expired with nonzero count");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: timeout counter / calendar clock unit testbench
// Directed table and then randomized phases of request beats. Each beat is
// run through an in-house model of the counters and the clock, and every
// response beat is checked field by field, in order. The prescaler reload is
// rewritten between phases while the unit is idle. Both channels idle at
// random, except in the final phase.
// ----------------------------------------------------------------------------

module tb_top;

    import ttc_pkg::*;

    localparam int NUM_TMO       = NUM_TIMEOUTS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 2 * (NUM_TMO + 3);
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_BEATS   = 112;
    localparam int MAX_REPORTS   = 60;

    // command codes the unit must treat as no-ops
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // one row of the directed table; want is used only when fixed is set
    typedef struct {
        ttc_req_t req;
        int       reps;
        bit       fixed;
        ttc_rsp_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    ttc_stream_if #(.T(ttc_req_t)) req_ch ();
    ttc_stream_if #(.T(ttc_rsp_t)) rsp_ch ();
    ttc_stream_if #(.T(ttc_cfg_t)) cfg_ch ();

    tick_timeouts_and_calendar_clock_unit #(
        .NUM_TIMEOUTS (NUM_TMO)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // Model state: counters, prescaler, reload register and calendar
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] timeout_left [NUM_TMO];
    logic [7:0]       prescale_left;
    logic [7:0]       reload_cfg;
    ttc_time_t        cal_now;

    ttc_rsp_t  clock_status_q [$];   // predicted response beats, oldest first
    plan_row_t plan_q [$];

    int  mismatches;
    int  cycle_count;
    int  seconds_advanced;
    int  reload_writes;
    int  beats_by_cmd [8];
    bit  quiet;                      // no idling on either side when set

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run stalled at cycle %0d, %0d beats still due", $time,
                     cycle_count, clock_status_q.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic void clear_model();
        foreach (timeout_left[i])
            timeout_left[i] = '0;
        prescale_left = RELOAD_RESET;
        reload_cfg    = RELOAD_RESET;
        cal_now       = '0;
    endfunction

    // One second with the cascade of carries. A value set past its limit carries
    // at once, but 255 wraps to 0 with no carry; the check only looks at "> limit".
    function automatic void bump_second();
        seconds_advanced++;
        cal_now.sec = cal_now.sec + 8'd1;
        if (cal_now.sec > SEC_LIMIT)
        begin
            cal_now.sec = '0;
            cal_now.min = cal_now.min + 8'd1;
            if (cal_now.min > MIN_LIMIT)
            begin
                cal_now.min  = '0;
                cal_now.hour = cal_now.hour + 8'd1;
                if (cal_now.hour > HOUR_LIMIT)
                begin
                    cal_now.hour = '0;
                    cal_now.day  = cal_now.day + 8'd1;
                    if (cal_now.day > DAY_LIMIT)
                    begin
                        // day and month restart at 0, not 1
                        cal_now.day   = '0;
                        cal_now.month = cal_now.month + 8'd1;
                        if (cal_now.month > MONTH_LIMIT)
                        begin
                            cal_now.month = '0;
                            cal_now.year  = cal_now.year + 8'd1;
                        end
                    end
                end
            end
        end
    endfunction

    // Applies one request beat to the model and returns the response it owes.
    function automatic ttc_rsp_t predict_status(input ttc_req_t r);
        ttc_rsp_t s;
        s = '0;
        beats_by_cmd[r.cmd]++;
        case (r.cmd)
            CMD_TICK:
            begin
                // counters stop at zero; prescaler reloads only once at zero
                foreach (timeout_left[i])
                    if (timeout_left[i] != '0)
                        timeout_left[i] = timeout_left[i] - 1'b1;
                if (prescale_left != '0)
                    prescale_left = prescale_left - 8'd1;
                else
                begin
                    prescale_left = reload_cfg;
                    bump_second();
                end
            end
            CMD_LOAD:
            begin
                // out-of-range index: no effect
                if (r.timer_index < NUM_TMO)
                    timeout_left[r.timer_index] = r.load_value;
            end
            CMD_SET_TIME:
            begin
                cal_now.hour = r.value_a;
                cal_now.min  = r.value_b;
                cal_now.sec  = r.value_c;
            end
            CMD_SET_DATE:
            begin
                cal_now.year  = r.value_a;
                cal_now.month = r.value_b;
                cal_now.day   = r.value_c;
            end
            CMD_READ:
            begin
                // out-of-range read looks like an expired counter
                if (r.timer_index < NUM_TMO)
                begin
                    s.read_count   = timeout_left[r.timer_index];
                    s.read_expired = (timeout_left[r.timer_index] == '0);
                end
                else
                begin
                    s.read_count   = '0;
                    s.read_expired = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < NUM_TMO && i < MASK_W; i++)
            s.expired_mask[i] = (timeout_left[i] == '0);
        s.second    = cal_now.sec;
        s.minute    = cal_now.min;
        s.hour_now  = cal_now.hour;
        s.day_now   = cal_now.day;
        s.month_now = cal_now.month;
        s.year_now  = cal_now.year;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic ttc_req_t mk_req(input logic [2:0] cmd, input logic [3:0] idx,
                                        input logic [15:0] load, input logic [7:0] a,
                                        input logic [7:0] b, input logic [7:0] c);
        ttc_req_t r;
        r.cmd         = cmd;
        r.timer_index = idx;
        r.load_value  = load;
        r.value_a     = a;
        r.value_b     = b;
        r.value_c     = c;
        return r;
    endfunction

    function automatic ttc_rsp_t mk_status(input logic [7:0] sec, input logic [7:0] min,
                                           input logic [7:0] hour, input logic [7:0] day,
                                           input logic [7:0] month, input logic [7:0] year,
                                           input logic [7:0] mask, input logic [15:0] cnt,
                                           input logic expired);
        ttc_rsp_t s;
        s.second       = sec;
        s.minute       = min;
        s.hour_now     = hour;
        s.day_now      = day;
        s.month_now    = month;
        s.year_now     = year;
        s.expired_mask = mask;
        s.read_count   = cnt;
        s.read_expired = expired;
        return s;
    endfunction

    task automatic add_row(input ttc_req_t r, input int reps, input bit fixed,
                           input ttc_rsp_t want);
        plan_row_t row;
        row.req   = r;
        row.reps  = reps;
        row.fixed = fixed;
        row.want  = want;
        plan_q.push_back(row);
    endtask

    // Random beat: every field random, then the command and the fields it uses
    // are biased so carries and expiries happen often.
    function automatic ttc_req_t random_request();
        ttc_req_t r;
        int       pick;
        r.cmd         = CMD_TICK;
        r.timer_index = 4'($urandom_range(0, 15));
        r.load_value  = 16'($urandom_range(0, 65535));
        r.value_a     = 8'($urandom_range(0, 255));
        r.value_b     = 8'($urandom_range(0, 255));
        r.value_c     = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 52)
            r.cmd = CMD_TICK;
        else if (pick < 66)
        begin
            r.cmd = CMD_LOAD;
            if ($urandom_range(0, 7) != 0)
                r.timer_index = 4'($urandom_range(0, NUM_TMO - 1));
            if ($urandom_range(0, 3) != 0)
                r.load_value = 16'($urandom_range(0, 40));   // short, so it runs out
        end
        else if (pick < 74)
        begin
            r.cmd = CMD_SET_TIME;
            if ($urandom_range(0, 3) != 0)
            begin
                // just short of a minute/hour/day rollover
                r.value_a = 8'($urandom_range(20, 23));
                r.value_b = 8'($urandom_range(57, 59));
                r.value_c = 8'($urandom_range(50, 59));
            end
        end
        else if (pick < 81)
        begin
            r.cmd = CMD_SET_DATE;
            if ($urandom_range(0, 3) != 0)
            begin
                r.value_b = 8'($urandom_range(10, 12));
                r.value_c = 8'($urandom_range(28, 30));
            end
        end
        else if (pick < 96)
        begin
            r.cmd = CMD_READ;
            if ($urandom_range(0, 5) != 0)
                r.timer_index = 4'($urandom_range(0, NUM_TMO - 1));
        end
        else
            r.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: optional gap, then hold valid until the beat is taken.
    // valid stays high from one beat to the next when there is no gap.
    // ------------------------------------------------------------------------
    task automatic issue(input ttc_req_t r, input bit fixed, input ttc_rsp_t want);
        ttc_rsp_t guess;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        guess = predict_status(r);
        clock_status_q.push_back(fixed ? want : guess);
    endtask

    // Reload write, only once every owed response beat has come back.
    task automatic write_reload(input ttc_cfg_t v);
        while (clock_status_q.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        reload_cfg = v;
        reload_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall bursts on ready, none in the quiet phase
    // ------------------------------------------------------------------------
    initial
    begin : rsp_ready_gen
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (quiet)
                stall_left = 0;
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
                         want, got);
        end
    endtask

    // compare each response beat with the oldest prediction
    always @(posedge clk)
    begin : rsp_check
        ttc_rsp_t want;
        ttc_rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (clock_status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: response beat with none owed: expected nothing, actual %p",
                             $time, got);
            end
            else
            begin
                want = clock_status_q.pop_front();
                check_field("second",       want.second,       got.second);
                check_field("minute",       want.minute,       got.minute);
                check_field("hour_now",     want.hour_now,     got.hour_now);
                check_field("day_now",      want.day_now,      got.day_now);
                check_field("month_now",    want.month_now,    got.month_now);
                check_field("year_now",     want.year_now,     got.year_now);
                check_field("expired_mask", want.expired_mask, got.expired_mask);
                check_field("read_count",   want.read_count,   got.read_count);
                check_field("read_expired", want.read_expired, got.read_expired);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. Fixed rows are values that follow directly from reset
    // and the rows above; the rest are left to the model.
    // ------------------------------------------------------------------------
    task automatic build_plan();
        ttc_rsp_t none;
        none = '0;
        // fresh out of reset: all counters expired, clock at zero
        add_row(mk_req(CMD_READ, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 16'd0, 1'b1));
        // reads past the last counter: zero count, flagged expired
        add_row(mk_req(CMD_READ, 4'd15, 16'hFFFF, 8'd255, 8'd255, 8'd255), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 16'd0, 1'b1));
        add_row(mk_req(CMD_READ, 4'd8, 16'd0, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 16'd0, 1'b1));
        // spare command codes change nothing and do not flag a read
        add_row(mk_req(CMD_SPARE_HI, 4'd3, 16'hFFFF, 8'd255, 8'd255, 8'd255), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 16'd0, 1'b0));
        add_row(mk_req(CMD_SPARE_LO, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 16'd0, 1'b0));
        // loads past the last counter are dropped, then counters 0 and 7 are loaded
        add_row(mk_req(CMD_LOAD, 4'd15, 16'hFFFF, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 16'd0, 1'b0));
        add_row(mk_req(CMD_LOAD, 4'd8, 16'h1234, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 16'd0, 1'b0));
        add_row(mk_req(CMD_LOAD, 4'd0, 16'hFFFF, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFE, 16'd0, 1'b0));
        add_row(mk_req(CMD_LOAD, 4'd7, 16'd1, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h7E, 16'd0, 1'b0));
        add_row(mk_req(CMD_READ, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h7E, 16'hFFFF, 1'b0));
        // last second of the last day of the last month of year 255
        add_row(mk_req(CMD_SET_TIME, 4'd0, 16'd0, 8'd23, 8'd59, 8'd59), 1, 1,
                mk_status(8'd59, 8'd59, 8'd23, 8'd0, 8'd0, 8'd0, 8'h7E, 16'd0, 1'b0));
        add_row(mk_req(CMD_SET_DATE, 4'd0, 16'd0, 8'd255, 8'd12, 8'd30), 1, 1,
                mk_status(8'd59, 8'd59, 8'd23, 8'd30, 8'd12, 8'd255, 8'h7E, 16'd0, 1'b0));
        // drain the reset prescaler, then one tick rolls every field over
        add_row(mk_req(CMD_TICK, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 100, 0, none);
        add_row(mk_req(CMD_TICK, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1, 1,
                mk_status(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFE, 16'd0, 1'b0));
        add_row(mk_req(CMD_READ, 4'd7, 16'd0, 8'd0, 8'd0, 8'd0), 1, 0, none);
        add_row(mk_req(CMD_READ, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1, 0, none);
        // set past the limits: 255 wraps to 0 with no carry
        add_row(mk_req(CMD_SET_TIME, 4'd0, 16'd0, 8'd255, 8'd255, 8'd255), 1, 1,
                mk_status(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'hFE, 16'd0, 1'b0));
        add_row(mk_req(CMD_TICK, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1, 0, none);
        // just past the limit: carries at once
        add_row(mk_req(CMD_SET_TIME, 4'd0, 16'd0, 8'd0, 8'd59, 8'd60), 1, 0, none);
        add_row(mk_req(CMD_TICK, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1, 0, none);
        add_row(mk_req(CMD_SET_DATE, 4'd0, 16'd0, 8'd0, 8'd13, 8'd31), 1, 0, none);
        add_row(mk_req(CMD_SET_TIME, 4'd0, 16'd0, 8'd23, 8'd59, 8'd59), 1, 0, none);
        add_row(mk_req(CMD_TICK, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1, 0, none);
        // explicit zero load, then a short count running out
        add_row(mk_req(CMD_LOAD, 4'd3, 16'd0, 8'd0, 8'd0, 8'd0), 1, 0, none);
        add_row(mk_req(CMD_LOAD, 4'd5, 16'd2, 8'd0, 8'd0, 8'd0), 1, 0, none);
        add_row(mk_req(CMD_TICK, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0), 3, 0, none);
        add_row(mk_req(CMD_READ, 4'd5, 16'd0, 8'd0, 8'd0, 8'd0), 1, 0, none);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        ttc_rsp_t none;
        ttc_cfg_t phase_reload;
        none             = '0;
        mismatches       = 0;
        cycle_count      = 0;
        seconds_advanced = 0;
        reload_writes    = 0;
        quiet            = 1'b0;
        foreach (beats_by_cmd[i])
            beats_by_cmd[i] = 0;

        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        rst_n        <= 1'b0;
        clear_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reload 0 from the start: once the reset count drains, every tick
        // is a second, which the directed rows rely on
        write_reload(8'd0);
        build_plan();
        foreach (plan_q[i])
            for (int k = 0; k < plan_q[i].reps; k++)
                issue(plan_q[i].req, plan_q[i].fixed, plan_q[i].want);

        // random phases, each under its own reload; both extremes included
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       phase_reload = 8'd1;
                1:       phase_reload = 8'd255;
                2:       phase_reload = 8'd0;
                3:       phase_reload = 8'($urandom_range(2, 9));
                4:       phase_reload = 8'd4;
                default: phase_reload = 8'd2;
            endcase
            req_ch.valid <= 1'b0;
            write_reload(phase_reload);
            quiet = (p == NUM_PHASES - 1);
            repeat (PHASE_BEATS)
                issue(random_request(), 1'b0, none);
        end
        req_ch.valid <= 1'b0;

        while (clock_status_q.size() != 0)
            @(posedge clk);
        // wait out TAIL_CYCLES to catch any stray response beat
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d ticks, %0d loads, %0d time sets, %0d date sets, %0d reads",
                 beats_by_cmd[CMD_TICK], beats_by_cmd[CMD_LOAD], beats_by_cmd[CMD_SET_TIME],
                 beats_by_cmd[CMD_SET_DATE], beats_by_cmd[CMD_READ]);
        $display("%0d seconds advanced under %0d reload writes, %0d mismatches",
                 seconds_advanced, reload_writes, mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ttc_pkg.sv
rtl/core/ttc_stream_if.sv
rtl/core/ttc_timer_bank.sv
rtl/core/ttc_calendar.sv
rtl/core/tick_timeouts_and_calendar_clock_unit.sv
dv/tb_top.sv
